[sv/sqa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqa_pkg
// shared codes, widths and arithmetic helpers of the attention block
// ---------------------------------------------------------------------------
package sqa_pkg;

	localparam int SEQ_MAX  = 256;
	localparam int HEAD_MAX = 64;
	localparam int TOK_W    = $clog2(SEQ_MAX);
	localparam int DIM_W    = $clog2(HEAD_MAX);

	// request modes
	localparam logic [2:0] MODE_QUERY = 3'd0;
	localparam logic [2:0] MODE_KEY   = 3'd1;
	localparam logic [2:0] MODE_VALUE = 3'd2;
	localparam logic [2:0] MODE_MASK  = 3'd3;
	localparam logic [2:0] MODE_START = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SEQ_LEN     = 3'd0;
	localparam logic [2:0] REG_HEAD_DIM    = 3'd1;
	localparam logic [2:0] REG_SCORE_SCALE = 3'd2;
	localparam logic [2:0] REG_MASK_SCALE  = 3'd3;
	localparam logic [2:0] REG_MASK_ENABLE = 3'd4;

	localparam int LOG2E_Q12 = 5909;

	// 2^(-k/16) in q1.16
	function automatic logic [16:0] pow2_tab(input logic [4:0] k);
		logic [16:0] r;
		begin
			unique case (k)
				5'd0:  r = 17'd65536;
				5'd1:  r = 17'd62757;
				5'd2:  r = 17'd60097;
				5'd3:  r = 17'd57549;
				5'd4:  r = 17'd55109;
				5'd5:  r = 17'd52773;
				5'd6:  r = 17'd50535;
				5'd7:  r = 17'd48393;
				5'd8:  r = 17'd46341;
				5'd9:  r = 17'd44376;
				5'd10: r = 17'd42495;
				5'd11: r = 17'd40693;
				5'd12: r = 17'd38968;
				5'd13: r = 17'd37316;
				5'd14: r = 17'd35734;
				5'd15: r = 17'd34219;
				default: r = 17'd32768;
			endcase
			return r;
		end
	endfunction

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
		logic signed [31:0] r;
		begin
			if (x > 44'sh0007FFFFFFF)
				r = 32'sh7FFFFFFF;
			else if (x < -44'sh00080000000)
				r = 32'sh80000000;
			else
				r = x[31:0];
			return r;
		end
	endfunction

endpackage

[sv/sqa_exp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqa_exp
// four stage exp(-d) unit, d in q.12, result in q1.16
// ---------------------------------------------------------------------------
module sqa_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] d,
	output logic        done,
	output logic [16:0] e
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [45:0] p_s1;
	logic        big_s2, big_s3;
	logic [4:0]  i_s2, i_s3;
	logic [3:0]  k_s2;
	logic [7:0]  f_s2;
	logic [16:0] m_s3;
	logic [16:0] e_s4;

	logic [33:0] y;
	logic [16:0] t0, t1;
	logic [20:0] dm;
	logic [16:0] m_nxt;
	logic [17:0] rnd;
	logic [16:0] e_nxt;

	always_comb begin
		y     = 34'((p_s1 + 46'd2048) >> 12);
		t0    = sqa_pkg::pow2_tab({1'b0, k_s2});
		t1    = sqa_pkg::pow2_tab(5'({1'b0, k_s2}) + 5'd1);
		dm    = 21'((t0 - t1) * 17'(f_s2));
		m_nxt = t0 - 17'((dm + 21'd128) >> 8);
		if (i_s3 == 5'd0)
			rnd = {1'b0, m_s3};
		else
			rnd = {1'b0, m_s3} + (18'd1 << (i_s3 - 5'd1));
		e_nxt = big_s3 ? 17'd0 : 17'(rnd >> i_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= 46'(d) * 46'(sqa_pkg::LOG2E_Q12);
		big_s2 <= |y[33:17];
		i_s2   <= y[16:12];
		k_s2   <= y[11:8];
		f_s2   <= y[7:0];
		m_s3   <= m_nxt;
		i_s3   <= i_s2;
		big_s3 <= big_s2;
		e_s4   <= e_nxt;
	end

	assign done = v_s4;
	assign e    = e_s4;

endmodule

[sv/sqa_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqa_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module sqa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [24:0] den,
	output logic        done,
	output logic [33:0] quo
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [33:0] quo_q;
	logic [25:0] rem_q;
	logic [24:0] den_q;
	logic [25:0] rem_sh;
	logic        ge;

	always_comb begin
		rem_sh = {rem_q[24:0], quo_q[33]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd33) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= 26'd0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[32:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

[sv/single_query_attention.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// single_query_attention
// scaled dot-product attention with softmax for one query row
// ---------------------------------------------------------------------------
// usage: requests enter on in_valid/in_stall. mode query, key, value and mask
// requests write one element into on-chip memory. a start request walks the
// stores: scores, exp and running sum, one reciprocal, normalization, then D
// context values, the one shared multiply-accumulate path reading one key or
// value per cycle. results leave on out_valid/out_stall through an output
// register; last marks the final context value. while the receiver stalls,
// the next context value waits finished until the register drains.
// in_stall is high for the whole start computation.
// reset clears control and config registers to their defaults; element
// memories hold garbage until loaded. config writes are for the user to make
// only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module single_query_attention (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  token_index,
	input  logic [5:0]  dim_index,
	input  logic signed [15:0] element_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  out_index,
	output logic signed [31:0] out_value,
	output logic        last
);

	localparam int TW = sqa_pkg::TOK_W;
	localparam int DW = sqa_pkg::DIM_W;

	// sequencer codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SC_RUN  = 4'd1;
	localparam logic [3:0] ST_SC_MUL1 = 4'd2;
	localparam logic [3:0] ST_SC_MUL2 = 4'd3;
	localparam logic [3:0] ST_SC_FIN  = 4'd4;
	localparam logic [3:0] ST_EX_RD   = 4'd5;
	localparam logic [3:0] ST_EX_GO   = 4'd6;
	localparam logic [3:0] ST_EX_WAIT = 4'd7;
	localparam logic [3:0] ST_DIV     = 4'd8;
	localparam logic [3:0] ST_NM_RD   = 4'd9;
	localparam logic [3:0] ST_NM_MUL  = 4'd10;
	localparam logic [3:0] ST_NM_WR   = 4'd11;
	localparam logic [3:0] ST_OUT_RUN = 4'd12;
	localparam logic [3:0] ST_OUT_FIN = 4'd13;

	// config registers
	logic [8:0]  seq_len_q;
	logic [6:0]  head_dim_q;
	logic [15:0] score_scale_q;
	logic signed [15:0] mask_scale_q;
	logic        mask_enable_q;

	// element memories
	logic signed [15:0] q_mem [sqa_pkg::HEAD_MAX];
	logic signed [15:0] k_mem [sqa_pkg::SEQ_MAX * sqa_pkg::HEAD_MAX];
	logic signed [15:0] v_mem [sqa_pkg::SEQ_MAX * sqa_pkg::HEAD_MAX];
	logic signed [15:0] m_mem [sqa_pkg::SEQ_MAX];
	logic signed [31:0] w_mem [sqa_pkg::SEQ_MAX];

	logic signed [15:0] q_rd_q, k_rd_q, v_rd_q, m_rd_q;
	logic signed [31:0] w_rd_q;

	// sequencer state
	logic [3:0]    state_q;
	logic [TW-1:0] tok_q;
	logic [DW-1:0] dim_q;
	logic          issuing_q;
	logic          rd_v_s1, mul_v_s2;
	logic signed [33:0] prod_s2;
	logic signed [41:0] acc_q;
	logic [32:0]   plo_q;
	logic signed [31:0] pmask_q;
	logic signed [37:0] phi_q;
	logic signed [31:0] mx_q;
	logic [24:0]   sum_q;
	logic [16:0]   inv_q;
	logic [33:0]   nprod_q;

	// output register
	logic        out_valid_q;
	logic [5:0]  out_index_q;
	logic signed [31:0] out_value_q;
	logic        last_q;

	logic          in_acc, out_acc, out_load;
	logic [TW-1:0] seq_m1;
	logic [DW-1:0] dim_m1;
	logic          iss, drained, sc_phase;
	logic          w_we;
	logic [31:0]   w_wd;
	logic signed [17:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [54:0] full;
	logic signed [32:0] mrnd;
	logic signed [43:0] sc_wide;
	logic signed [31:0] sc;
	logic signed [32:0] dsub;
	logic signed [41:0] orow;

	// exp and divider handshakes
	logic        exp_start, exp_done;
	logic [16:0] exp_e;
	logic        div_start, div_done;
	logic [33:0] div_quo;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = state_q != ST_IDLE;
	// the finished context value moves into the output register
	assign out_load = state_q == ST_OUT_FIN && (!out_valid_q || !out_stall);

	// clamp lengths to the store sizes
	always_comb begin
		if (seq_len_q == 9'd0)
			seq_m1 = '0;
		else if (seq_len_q > 9'(sqa_pkg::SEQ_MAX))
			seq_m1 = TW'(sqa_pkg::SEQ_MAX - 1);
		else
			seq_m1 = TW'(seq_len_q - 9'd1);
		if (head_dim_q == 7'd0)
			dim_m1 = '0;
		else if (head_dim_q > 7'(sqa_pkg::HEAD_MAX))
			dim_m1 = DW'(sqa_pkg::HEAD_MAX - 1);
		else
			dim_m1 = DW'(head_dim_q - 7'd1);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q     <= 9'd1;
			head_dim_q    <= 7'd64;
			score_scale_q <= 16'd4096;
			mask_scale_q  <= 16'sd4096;
			mask_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqa_pkg::REG_SEQ_LEN:     seq_len_q <= cfg_data[8:0];
				sqa_pkg::REG_HEAD_DIM:    head_dim_q <= cfg_data[6:0];
				sqa_pkg::REG_SCORE_SCALE: score_scale_q <= cfg_data;
				sqa_pkg::REG_MASK_SCALE:  mask_scale_q <= $signed(cfg_data);
				sqa_pkg::REG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// element memories: loads write, the sequencer reads at tok_q/dim_q
	always_ff @(posedge clk) begin
		if (in_acc && mode == sqa_pkg::MODE_QUERY)
			q_mem[dim_index] <= element_value;
		q_rd_q <= q_mem[dim_q];
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == sqa_pkg::MODE_KEY)
			k_mem[{token_index, dim_index}] <= element_value;
		k_rd_q <= k_mem[{tok_q, dim_q}];
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == sqa_pkg::MODE_VALUE)
			v_mem[{token_index, dim_index}] <= element_value;
		v_rd_q <= v_mem[{tok_q, dim_q}];
	end

	always_ff @(posedge clk) begin
		if (in_acc && mode == sqa_pkg::MODE_MASK)
			m_mem[token_index] <= element_value;
		m_rd_q <= m_mem[tok_q];
	end

	// weight store holds scores, then exps, then normalized weights
	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[tok_q] <= w_wd;
		w_rd_q <= w_mem[tok_q];
	end

	// shared multiply-accumulate path: q*k for scores, w*v for context
	assign sc_phase = state_q == ST_SC_RUN;
	assign iss      = (state_q == ST_SC_RUN || state_q == ST_OUT_RUN) && issuing_q;
	assign drained  = !issuing_q && !rd_v_s1 && !mul_v_s2;

	always_comb begin
		mul_a = sc_phase ? 18'(q_rd_q) : $signed({1'b0, w_rd_q[16:0]});
		mul_b = sc_phase ? k_rd_q : v_rd_q;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 34'(mul_a * mul_b);
	end

	// score epilogue: rshr(dot*scale,24) plus, when the mask is enabled, rshr(mask*mask_scale,12)
	always_comb begin
		full    = ($signed({phi_q, 17'd0}) + $signed({22'd0, plo_q})) + 55'sd8388608;
		mrnd    = 33'(pmask_q) + 33'sd2048;
		sc_wide = 44'($signed(full[54:24]));
		if (mask_enable_q)
			sc_wide = sc_wide + 44'($signed(mrnd[32:12]));
		sc   = sqa_pkg::sat32(sc_wide);
		dsub = 33'(mx_q) - 33'(w_rd_q);
		orow = (acc_q + 42'sd2048) >>> 12;
	end

	// weight store writes
	always_comb begin
		w_we = 1'b0;
		w_wd = 32'(sc);
		unique case (state_q)
			ST_SC_FIN: begin
				w_we = 1'b1;
				w_wd = 32'(sc);
			end
			ST_EX_WAIT: begin
				w_we = exp_done;
				w_wd = 32'(exp_e);
			end
			ST_NM_WR: begin
				w_we = 1'b1;
				w_wd = 32'((nprod_q + 34'd32768) >> 16);
			end
			default: ;
		endcase
	end

	assign exp_start = state_q == ST_EX_GO;

	sqa_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (dsub[32:0]),
		.done   (exp_done),
		.e      (exp_e)
	);

	// reciprocal of the exp sum, rounded
	assign div_start = state_q == ST_EX_WAIT && exp_done && tok_q == seq_m1;

	sqa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((34'd1 << 32) + 34'((sum_q + 25'(exp_e)) >> 1)),
		.den    (sum_q + 25'(exp_e)),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tok_q       <= '0;
			dim_q       <= '0;
			issuing_q   <= 1'b0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= iss;
			mul_v_s2 <= rd_v_s1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;

			// issue counter of the multiply-accumulate walk
			if (iss) begin
				if (sc_phase) begin
					if (dim_q == dim_m1)
						issuing_q <= 1'b0;
					else
						dim_q <= dim_q + 1'b1;
				end else begin
					if (tok_q == seq_m1)
						issuing_q <= 1'b0;
					else
						tok_q <= tok_q + 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && mode == sqa_pkg::MODE_START) begin
						state_q   <= ST_SC_RUN;
						tok_q     <= '0;
						dim_q     <= '0;
						issuing_q <= 1'b1;
					end
				end
				ST_SC_RUN: begin
					if (drained)
						state_q <= ST_SC_MUL1;
				end
				ST_SC_MUL1: state_q <= ST_SC_MUL2;
				ST_SC_MUL2: state_q <= ST_SC_FIN;
				ST_SC_FIN: begin
					if (tok_q == seq_m1) begin
						tok_q   <= '0;
						state_q <= ST_EX_RD;
					end else begin
						tok_q     <= tok_q + 1'b1;
						dim_q     <= '0;
						issuing_q <= 1'b1;
						state_q   <= ST_SC_RUN;
					end
				end
				ST_EX_RD: state_q <= ST_EX_GO;
				ST_EX_GO: state_q <= ST_EX_WAIT;
				ST_EX_WAIT: begin
					if (exp_done) begin
						if (tok_q == seq_m1) begin
							state_q <= ST_DIV;
						end else begin
							tok_q   <= tok_q + 1'b1;
							state_q <= ST_EX_RD;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						tok_q   <= '0;
						state_q <= ST_NM_RD;
					end
				end
				ST_NM_RD: state_q <= ST_NM_MUL;
				ST_NM_MUL: state_q <= ST_NM_WR;
				ST_NM_WR: begin
					if (tok_q == seq_m1) begin
						tok_q     <= '0;
						dim_q     <= '0;
						issuing_q <= 1'b1;
						state_q   <= ST_OUT_RUN;
					end else begin
						tok_q   <= tok_q + 1'b1;
						state_q <= ST_NM_RD;
					end
				end
				ST_OUT_RUN: begin
					if (drained)
						state_q <= ST_OUT_FIN;
				end
				ST_OUT_FIN: begin
					// hand the context value over once the output register is free
					if (out_load) begin
						if (dim_q == dim_m1) begin
							state_q <= ST_IDLE;
						end else begin
							dim_q     <= dim_q + 1'b1;
							tok_q     <= '0;
							issuing_q <= 1'b1;
							state_q   <= ST_OUT_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// the accumulator holds a finished context value until it is handed over
		if ((state_q == ST_IDLE) || (state_q == ST_SC_FIN) || (state_q == ST_NM_WR) ||
				out_load)
			acc_q <= '0;
		else if (mul_v_s2)
			acc_q <= acc_q + 42'(prod_s2);

		if (state_q == ST_SC_MUL1) begin
			plo_q   <= 33'(acc_q[16:0]) * 33'(score_scale_q);
			pmask_q <= 32'(m_rd_q * mask_scale_q);
		end
		if (state_q == ST_SC_MUL2)
			phi_q <= 38'($signed(acc_q[37:17]) * $signed({1'b0, score_scale_q}));

		// running maximum of the scores
		if (state_q == ST_SC_FIN && (tok_q == '0 || sc > mx_q))
			mx_q <= sc;

		if (state_q == ST_SC_FIN)
			sum_q <= '0;
		else if (state_q == ST_EX_WAIT && exp_done)
			sum_q <= sum_q + 25'(exp_e);

		if (div_done)
			inv_q <= div_quo[16:0];

		if (state_q == ST_NM_MUL)
			nprod_q <= 34'(w_rd_q[16:0]) * 34'(inv_q);

		if (out_load) begin
			out_index_q <= 6'(dim_q);
			out_value_q <= sqa_pkg::sat32(44'(orow));
			last_q      <= dim_q == dim_m1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule
